// ===== hdl/lrs_pkg.sv =====
// Shared constants and transfer types for the linear interpolation resampler.
package lrs_pkg;

    localparam int OUT_PER_MS_DEF = 2048;
    localparam int RATE_MIN       = 1500;
    localparam int RATE_MAX       = 2500;
    localparam int RATE_RESET     = 2000;

    localparam int SAMPLE_W   = 16;
    localparam int RESULT_W   = 27;
    localparam int CFG_W      = 12;
    localparam int IDX_W      = 2;
    localparam int OP_F_W     = 13;
    localparam int OPQ_DEPTH  = 2;
    localparam int OUTQ_DEPTH = 4;

    localparam logic [IDX_W-1:0] REG_SAMPLES_PER_MS = 2'd0;
    localparam logic [IDX_W-1:0] REG_RUN_ENABLE     = 2'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] prev_re;
        logic signed [SAMPLE_W-1:0] prev_im;
        logic signed [SAMPLE_W-1:0] cur_re;
        logic signed [SAMPLE_W-1:0] cur_im;
        logic [OP_F_W-1:0]          frac;
        logic                       last;
        logic                       bend;
    } op_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] re;
        logic signed [RESULT_W-1:0] im;
        logic                       last;
        logic                       bend;
    } res_t;

endpackage

// ===== hdl/linear_interp_resampler_to_2048.sv =====
// Top level of the linear interpolation resampler to OUT_PER_MS samples per ms.
// Path: an input is registered in the front end, then its ops pass the op queue,
// the multiply-stage registers and the result queue before they become visible.
// Throughput: one input per cycle if it yields at most one result and the op queue
// has room; the front end issues one op per cycle while the op queue is not full.
// Reset: asynchronous, for control state only; rate register to 2000, run flag off.
module linear_interp_resampler_to_2048 #(
    parameter int OUT_PER_MS = lrs_pkg::OUT_PER_MS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [lrs_pkg::IDX_W-1:0]           wr_index,
    input  logic [lrs_pkg::CFG_W-1:0]           wr_data,
    input  logic                                push,
    output logic                                full,
    input  logic signed [lrs_pkg::SAMPLE_W-1:0] in_re,
    input  logic signed [lrs_pkg::SAMPLE_W-1:0] in_im,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [lrs_pkg::RESULT_W-1:0] out_re,
    output logic signed [lrs_pkg::RESULT_W-1:0] out_im,
    output logic                                run_last,
    output logic                                block_end
);

    lrs_pkg::op_t op_wr;
    logic [$bits(lrs_pkg::op_t)-1:0] op_rd;
    logic op_push;
    logic op_full;
    logic op_pop;
    logic op_empty;
    logic [$clog2(lrs_pkg::OPQ_DEPTH+1)-1:0] op_count;

    lrs_front #(
        .OUT_PER_MS (OUT_PER_MS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .in_re    (in_re),
        .in_im    (in_im),
        .full     (full),
        .op_push  (op_push),
        .op_data  (op_wr),
        .op_full  (op_full)
    );

    lrs_fifo #(
        .WIDTH ($bits(lrs_pkg::op_t)),
        .DEPTH (lrs_pkg::OPQ_DEPTH)
    ) u_opq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .wdata (op_wr),
        .full  (op_full),
        .pop   (op_pop),
        .rdata (op_rd),
        .empty (op_empty),
        .count (op_count)
    );

    lrs_back #(
        .OUT_PER_MS (OUT_PER_MS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_empty  (op_empty | (op_count == '0)),
        .op_data   (lrs_pkg::op_t'(op_rd)),
        .op_pop    (op_pop),
        .empty     (empty),
        .pop       (pop),
        .out_re    (out_re),
        .out_im    (out_im),
        .run_last  (run_last),
        .block_end (block_end)
    );

endmodule

// ===== hdl/lrs_fifo.sv =====
// Small register FIFO with occupancy count.
module lrs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             wdata,
    output logic                         full,
    input  logic                         pop,
    output logic [WIDTH-1:0]             rdata,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH-1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH-1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/lrs_front.sv =====
// Front end: config registers, position tracking and issue of interpolation ops.
module lrs_front #(
    parameter int OUT_PER_MS = lrs_pkg::OUT_PER_MS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [lrs_pkg::IDX_W-1:0]           wr_index,
    input  logic [lrs_pkg::CFG_W-1:0]           wr_data,
    input  logic                                push,
    input  logic signed [lrs_pkg::SAMPLE_W-1:0] in_re,
    input  logic signed [lrs_pkg::SAMPLE_W-1:0] in_im,
    output logic                                full,
    output logic                                op_push,
    output lrs_pkg::op_t                        op_data,
    input  logic                                op_full
);

    localparam int FW  = $clog2(OUT_PER_MS);
    localparam int OIW = $clog2(OUT_PER_MS+1);
    localparam int CW  = $clog2(2*OUT_PER_MS+1);
    localparam int NW  = lrs_pkg::CFG_W;
    localparam int SW  = lrs_pkg::SAMPLE_W;
    localparam int RATE_HALF = (OUT_PER_MS + 1) / 2;
    localparam int RATE_LO   = (RATE_HALF > lrs_pkg::RATE_MIN) ? RATE_HALF : lrs_pkg::RATE_MIN;
    localparam int RATE_HI   = lrs_pkg::RATE_MAX;
    localparam int RATE_RST  = (lrs_pkg::RATE_RESET < RATE_LO) ? RATE_LO :
                               ((lrs_pkg::RATE_RESET > RATE_HI) ? RATE_HI : lrs_pkg::RATE_RESET);

    logic [NW-1:0]        n_reg, n_next;
    logic                 run_reg, run_next;
    logic signed [SW-1:0] prev_re_reg, prev_re_next;
    logic signed [SW-1:0] prev_im_reg, prev_im_next;
    logic signed [SW-1:0] cur_re_reg, cur_re_next;
    logic signed [SW-1:0] cur_im_reg, cur_im_next;
    logic [NW-1:0]        sidx_reg, sidx_next;
    logic [NW-1:0]        pint_reg, pint_next;
    logic [FW-1:0]        pfrac_reg, pfrac_next;
    logic [OIW-1:0]       oidx_reg, oidx_next;
    logic                 cnt_reg, cnt_next;
    logic                 item_v_reg, item_v_next;

    logic [CW-1:0]  n_cw;
    logic           pass_mode;
    logic [1:0]     n_int;
    logic [FW-1:0]  n_frac;
    logic [FW:0]    frac_sum;
    logic           carry;
    logic [FW-1:0]  pfrac_adv;
    logic [NW-1:0]  pint_adv;
    logic [OIW-1:0] oidx_adv;
    logic [NW-1:0]  sidx_m1;
    logic [NW-1:0]  sidx_inc;
    logic           cond;
    logic           next_ok;
    logic           done;
    logic           fin;
    logic           cfg_hit;
    logic [NW-1:0]  rate_clamped;

    // Split the per-output step into whole samples and fraction of a sample.
    always_comb
    begin
        n_cw = CW'(n_reg);
        if (n_cw >= CW'(2*OUT_PER_MS))
        begin
            n_int  = 2'd2;
            n_frac = FW'(n_cw - CW'(2*OUT_PER_MS));
        end
        else if (n_cw >= CW'(OUT_PER_MS))
        begin
            n_int  = 2'd1;
            n_frac = FW'(n_cw - CW'(OUT_PER_MS));
        end
        else
        begin
            n_int  = 2'd0;
            n_frac = FW'(n_cw);
        end
    end

    assign pass_mode = (n_cw == CW'(OUT_PER_MS));
    assign frac_sum  = {1'b0, pfrac_reg} + {1'b0, n_frac};
    assign carry     = (frac_sum >= (FW+1)'(OUT_PER_MS));
    assign pfrac_adv = carry ? FW'(frac_sum - (FW+1)'(OUT_PER_MS)) : FW'(frac_sum);
    assign pint_adv  = pint_reg + NW'(n_int) + NW'(carry);
    assign oidx_adv  = oidx_reg + 1'b1;
    assign sidx_m1   = sidx_reg - 1'b1;
    assign sidx_inc  = sidx_reg + 1'b1;
    assign cond      = (oidx_reg < OIW'(OUT_PER_MS)) && (pint_reg == sidx_m1);
    assign next_ok   = !cnt_reg && (oidx_adv < OIW'(OUT_PER_MS)) && (pint_adv == sidx_m1);

    assign cfg_hit = wr_en && ((wr_index == lrs_pkg::REG_SAMPLES_PER_MS) ||
                               (wr_index == lrs_pkg::REG_RUN_ENABLE));

    always_comb
    begin
        if (wr_data < NW'(RATE_LO))
        begin
            rate_clamped = NW'(RATE_LO);
        end
        else if (wr_data > NW'(RATE_HI))
        begin
            rate_clamped = NW'(RATE_HI);
        end
        else
        begin
            rate_clamped = wr_data;
        end
    end

    always_comb
    begin
        n_next       = n_reg;
        run_next     = run_reg;
        prev_re_next = prev_re_reg;
        prev_im_next = prev_im_reg;
        cur_re_next  = cur_re_reg;
        cur_im_next  = cur_im_reg;
        sidx_next    = sidx_reg;
        pint_next    = pint_reg;
        pfrac_next   = pfrac_reg;
        oidx_next    = oidx_reg;
        cnt_next     = cnt_reg;
        item_v_next  = item_v_reg;
        done         = 1'b0;
        fin          = 1'b0;
        op_push      = 1'b0;

        op_data.prev_re = prev_re_reg;
        op_data.prev_im = prev_im_reg;
        op_data.cur_re  = cur_re_reg;
        op_data.cur_im  = cur_im_reg;
        op_data.frac    = lrs_pkg::OP_F_W'(pfrac_reg);
        op_data.last    = !next_ok;
        op_data.bend    = (oidx_reg == OIW'(OUT_PER_MS-1));

        if (item_v_reg)
        begin
            if (pass_mode)
            begin
                op_data.prev_re = cur_re_reg;
                op_data.prev_im = cur_im_reg;
                op_data.frac    = '0;
                op_data.last    = 1'b1;
                op_data.bend    = (oidx_reg >= OIW'(OUT_PER_MS-1));
                if (!op_full)
                begin
                    op_push   = 1'b1;
                    done      = 1'b1;
                    oidx_next = op_data.bend ? '0 : oidx_adv;
                end
            end
            else if (sidx_reg == '0)
            begin
                // first sample of a fresh block only primes the history
                prev_re_next = cur_re_reg;
                prev_im_next = cur_im_reg;
                sidx_next    = NW'(1);
                done         = 1'b1;
            end
            else if (!cond)
            begin
                fin  = 1'b1;
                done = 1'b1;
            end
            else if (!op_full)
            begin
                op_push    = 1'b1;
                oidx_next  = oidx_adv;
                pint_next  = pint_adv;
                pfrac_next = pfrac_adv;
                cnt_next   = 1'b1;
                if (!next_ok)
                begin
                    fin  = 1'b1;
                    done = 1'b1;
                end
            end
        end

        if (fin)
        begin
            prev_re_next = cur_re_reg;
            prev_im_next = cur_im_reg;
            cnt_next     = 1'b0;
            if (sidx_inc > n_reg)
            begin
                // block complete: last sample carries over as sample 0
                sidx_next  = NW'(1);
                pint_next  = '0;
                pfrac_next = '0;
                oidx_next  = '0;
            end
            else
            begin
                sidx_next = sidx_inc;
            end
        end

        if (done)
        begin
            item_v_next = 1'b0;
        end

        if (push && !full && run_reg)
        begin
            item_v_next = 1'b1;
            cur_re_next = in_re;
            cur_im_next = in_im;
        end

        if (cfg_hit)
        begin
            if (wr_index == lrs_pkg::REG_SAMPLES_PER_MS)
            begin
                n_next = rate_clamped;
            end
            else
            begin
                run_next = wr_data[0];
            end
            prev_re_next = '0;
            prev_im_next = '0;
            sidx_next    = '0;
            pint_next    = '0;
            pfrac_next   = '0;
            oidx_next    = '0;
            cnt_next     = 1'b0;
            item_v_next  = 1'b0;
        end
    end

    assign full = item_v_reg && !done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg       <= NW'(RATE_RST);
            run_reg     <= 1'b0;
            prev_re_reg <= '0;
            prev_im_reg <= '0;
            sidx_reg    <= '0;
            pint_reg    <= '0;
            pfrac_reg   <= '0;
            oidx_reg    <= '0;
            cnt_reg     <= 1'b0;
            item_v_reg  <= 1'b0;
        end
        else
        begin
            n_reg       <= n_next;
            run_reg     <= run_next;
            prev_re_reg <= prev_re_next;
            prev_im_reg <= prev_im_next;
            sidx_reg    <= sidx_next;
            pint_reg    <= pint_next;
            pfrac_reg   <= pfrac_next;
            oidx_reg    <= oidx_next;
            cnt_reg     <= cnt_next;
            item_v_reg  <= item_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_re_reg <= cur_re_next;
        cur_im_reg <= cur_im_next;
    end

endmodule

// ===== hdl/lrs_back.sv =====
// Back end: weighted sum of neighbor samples and result queue.
module lrs_back #(
    parameter int OUT_PER_MS = lrs_pkg::OUT_PER_MS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                op_empty,
    input  lrs_pkg::op_t                        op_data,
    output logic                                op_pop,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [lrs_pkg::RESULT_W-1:0] out_re,
    output logic signed [lrs_pkg::RESULT_W-1:0] out_im,
    output logic                                run_last,
    output logic                                block_end
);

    localparam int WW  = $clog2(OUT_PER_MS+1);
    localparam int PW  = lrs_pkg::SAMPLE_W + WW + 1;
    localparam int QCW = $clog2(lrs_pkg::OUTQ_DEPTH+1);
    localparam int RW  = lrs_pkg::RESULT_W;

    logic [WW-1:0]        f_u;
    logic [WW-1:0]        w_u;
    logic signed [WW:0]   f_s;
    logic signed [WW:0]   w_s;
    logic signed [PW-1:0] pa_re, pb_re, pa_im, pb_im;
    logic signed [PW-1:0] pa_re_reg, pb_re_reg, pa_im_reg, pb_im_reg;
    logic                 last_reg, bend_reg;
    logic                 v1_reg;
    logic signed [PW:0]   sum_re, sum_im;
    logic [QCW-1:0]       oq_count;
    logic [QCW:0]         occ;
    logic                 oq_full;
    lrs_pkg::res_t        res_in, res_out;
    logic [$bits(lrs_pkg::res_t)-1:0] res_rd;

    // reserve a queue slot for the op in the multiply stage
    assign occ    = (QCW+1)'(oq_count) + (QCW+1)'(v1_reg);
    assign op_pop = !op_empty && !oq_full && (occ < (QCW+1)'(lrs_pkg::OUTQ_DEPTH));

    assign f_u   = WW'(op_data.frac);
    assign w_u   = WW'(OUT_PER_MS) - f_u;
    assign f_s   = $signed({1'b0, f_u});
    assign w_s   = $signed({1'b0, w_u});
    assign pa_re = PW'(op_data.prev_re) * PW'(w_s);
    assign pb_re = PW'(op_data.cur_re) * PW'(f_s);
    assign pa_im = PW'(op_data.prev_im) * PW'(w_s);
    assign pb_im = PW'(op_data.cur_im) * PW'(f_s);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= op_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            pa_re_reg <= pa_re;
            pb_re_reg <= pb_re;
            pa_im_reg <= pa_im;
            pb_im_reg <= pb_im;
            last_reg  <= op_data.last;
            bend_reg  <= op_data.bend;
        end
    end

    assign sum_re = (PW+1)'(pa_re_reg) + (PW+1)'(pb_re_reg);
    assign sum_im = (PW+1)'(pa_im_reg) + (PW+1)'(pb_im_reg);

    always_comb
    begin
        res_in.re   = sum_re[RW-1:0];
        res_in.im   = sum_im[RW-1:0];
        res_in.last = last_reg;
        res_in.bend = bend_reg;
    end

    lrs_fifo #(
        .WIDTH ($bits(lrs_pkg::res_t)),
        .DEPTH (lrs_pkg::OUTQ_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (v1_reg),
        .wdata (res_in),
        .full  (oq_full),
        .pop   (pop),
        .rdata (res_rd),
        .empty (empty),
        .count (oq_count)
    );

    assign res_out   = lrs_pkg::res_t'(res_rd);
    assign out_re    = res_out.re;
    assign out_im    = res_out.im;
    assign block_end = res_out.bend;
    assign run_last  = res_out.last;

endmodule

// ===== dv/tb_linear_interp_resampler_to_2048.sv =====
// Self-checking testbench for the I/Q resampler: queue-fed driver, checker with a predictor.
module tb_linear_interp_resampler_to_2048;

    localparam int IDX_W    = lrs_pkg::IDX_W;
    localparam int CFG_W    = lrs_pkg::CFG_W;
    localparam int SAMPLE_W = lrs_pkg::SAMPLE_W;
    localparam int RESULT_W = lrs_pkg::RESULT_W;
    localparam int RATE_MIN = lrs_pkg::RATE_MIN;
    localparam int RATE_MAX = lrs_pkg::RATE_MAX;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int OUTS          = lrs_pkg::OUT_PER_MS_DEF;

    // register slots past the list; the block must ignore them
    localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

    typedef lrs_pkg::res_t res_t;
    typedef enum int {MODE_RECV_STALLS, MODE_SEND_GAPS, MODE_NO_GAPS} gap_mode_t;
    typedef enum logic [1:0] {STIM_SAMPLE, STIM_WRITE, STIM_DRAIN} stim_kind_t;

    typedef struct {
        stim_kind_t                 kind;
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic [IDX_W-1:0]           idx;
        logic [CFG_W-1:0]           data;
        gap_mode_t                  mode;
    } stim_t;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       wr_en     = 1'b0;
    logic [IDX_W-1:0]           wr_index  = lrs_pkg::REG_SAMPLES_PER_MS;
    logic [CFG_W-1:0]           wr_data   = '0;
    logic                       push      = 1'b0;
    logic                       full;
    logic signed [SAMPLE_W-1:0] in_re     = '0;
    logic signed [SAMPLE_W-1:0] in_im     = '0;
    logic                       empty;
    logic                       pop       = 1'b0;
    logic signed [RESULT_W-1:0] out_re;
    logic signed [RESULT_W-1:0] out_im;
    logic                       run_last;
    logic                       block_end;

    stim_t     pending_in[$];
    res_t      expected_out[$];
    gap_mode_t fill_mode       = MODE_RECV_STALLS;
    gap_mode_t gap_mode        = MODE_RECV_STALLS;
    int        results_due     = 0;
    int        results_checked = 0;
    int        quiet_cycles    = 0;
    int        error_count     = 0;
    int        cycle_count     = 0;
    logic      drained         = 1'b0;

    // predictor state
    logic [CFG_W-1:0]           rate_reg = 12'd2000;
    logic                       run_reg  = 1'b0;
    logic signed [SAMPLE_W-1:0] hold_re  = '0;
    logic signed [SAMPLE_W-1:0] hold_im  = '0;
    int unsigned                samples_in_block = 0;
    int unsigned                pos_acc  = 0;
    int unsigned                out_count = 0;

    linear_interp_resampler_to_2048 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .push      (push),
        .full      (full),
        .in_re     (in_re),
        .in_im     (in_im),
        .empty     (empty),
        .pop       (pop),
        .out_re    (out_re),
        .out_im    (out_im),
        .run_last  (run_last),
        .block_end (block_end)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int send_gap_pct(gap_mode_t m);
        case (m)
            MODE_RECV_STALLS: return 12;
            MODE_SEND_GAPS:   return 86;
            default:          return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(gap_mode_t m);
        case (m)
            MODE_RECV_STALLS: return 86;
            MODE_SEND_GAPS:   return 12;
            default:          return 0;
        endcase
    endfunction

    // lower bound is also kept at half the output rate so a sample yields at most two results
    function automatic int unsigned clamped_rate();
        int unsigned n;
        int unsigned lo;
        lo = (OUTS + 1) / 2;
        if (lo < RATE_MIN)
            lo = RATE_MIN;
        n = rate_reg;
        if (n < lo)
            n = lo;
        if (n > RATE_MAX)
            n = RATE_MAX;
        return n;
    endfunction

    task automatic apply_reg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        if (idx == lrs_pkg::REG_SAMPLES_PER_MS)
            rate_reg = data;
        else if (idx == lrs_pkg::REG_RUN_ENABLE)
            run_reg = data[0];
        else
            return;
        hold_re          = '0;
        hold_im          = '0;
        samples_in_block = 0;
        pos_acc          = 0;
        out_count        = 0;
    endtask

    // Works out the results one accepted sample causes and queues them.
    task automatic resample_step(logic signed [SAMPLE_W-1:0] cur_re,
                                 logic signed [SAMPLE_W-1:0] cur_im);
        int unsigned n;
        int          made;
        longint      frac;
        longint      wgt;
        res_t        batch[2];
        n    = clamped_rate();
        made = 0;
        if (!run_reg)
            return;
        if (n == OUTS)
        begin
            batch[0].re   = RESULT_W'(longint'(cur_re) * OUTS);
            batch[0].im   = RESULT_W'(longint'(cur_im) * OUTS);
            batch[0].last = 1'b1;
            batch[0].bend = (out_count >= OUTS - 1);
            out_count     = batch[0].bend ? 0 : out_count + 1;
            expected_out  = {expected_out, batch[0]};
            results_due++;
            return;
        end
        if (samples_in_block == 0)
        begin
            hold_re          = cur_re;
            hold_im          = cur_im;
            samples_in_block = 1;
            return;
        end
        while (made < 2 && out_count < OUTS && pos_acc / OUTS == samples_in_block - 1)
        begin
            frac              = pos_acc % OUTS;
            wgt               = OUTS - frac;
            batch[made].re    = RESULT_W'(longint'(hold_re) * wgt + longint'(cur_re) * frac);
            batch[made].im    = RESULT_W'(longint'(hold_im) * wgt + longint'(cur_im) * frac);
            batch[made].last  = 1'b0;
            batch[made].bend  = (out_count == OUTS - 1);
            made++;
            out_count++;
            pos_acc += n;
        end
        if (made > 0)
            batch[made-1].last = 1'b1;
        for (int k = 0; k < made; k++)
        begin
            expected_out = {expected_out, batch[k]};
            results_due++;
        end
        hold_re = cur_re;
        hold_im = cur_im;
        samples_in_block++;
        // block done: last sample carries over as sample 0 of the next block
        if (samples_in_block > n)
        begin
            samples_in_block = 1;
            pos_acc          = 0;
            out_count        = 0;
        end
    endtask

    // Driver: presents queued samples, holds register writes until the block is quiet.
    always @(posedge clk)
    begin : driver
        stim_t head;
        logic  nxt_push;
        logic  nxt_wr;
        if (rst_n)
        begin
            nxt_push = push;
            nxt_wr   = 1'b0;
            if (wr_en)
                apply_reg_write(wr_index, wr_data);
            if (push && !full)
            begin
                resample_step(in_re, in_im);
                nxt_push = 1'b0;
            end
            if (push || wr_en || results_due != results_checked)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (!nxt_push && pending_in.size() != 0)
            begin
                head = pending_in[0];
                case (head.kind)
                    STIM_SAMPLE:
                    begin
                        if ($urandom_range(99) >= send_gap_pct(head.mode))
                        begin
                            head     = pending_in.pop_front();
                            nxt_push = 1'b1;
                            in_re    <= head.re;
                            in_im    <= head.im;
                            gap_mode <= head.mode;
                        end
                    end
                    STIM_WRITE:
                    begin
                        if (quiet_cycles >= SETTLE_CYCLES)
                        begin
                            head     = pending_in.pop_front();
                            nxt_wr   = 1'b1;
                            wr_index <= head.idx;
                            wr_data  <= head.data;
                        end
                    end
                    default:
                    begin
                        if (quiet_cycles >= SETTLE_CYCLES)
                            head = pending_in.pop_front();
                    end
                endcase
            end
            push    <= nxt_push;
            wr_en   <= nxt_wr;
            drained <= (pending_in.size() == 0 && !nxt_push && !nxt_wr &&
                        quiet_cycles >= SETTLE_CYCLES);
        end
    end

    // Monitor: checks each result transfer against the oldest expectation.
    always @(posedge clk)
    begin : monitor
        res_t got;
        res_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                got = '{re: out_re, im: out_im, last: run_last, bend: block_end};
                if (expected_out.size() == 0)
                begin
                    $display("%0t: unexpected result re=%0d im=%0d last=%0b end=%0b",
                             $time, got.re, got.im, got.last, got.bend);
                    error_count++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    results_checked <= results_checked + 1;
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected re=%0d im=%0d last=%0b end=%0b",
                                 $time, want.re, want.im, want.last, want.bend);
                        $display("%0t:          actual   re=%0d im=%0d last=%0b end=%0b",
                                 $time, got.re, got.im, got.last, got.bend);
                        error_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct(gap_mode));
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_sample(logic signed [SAMPLE_W-1:0] re, logic signed [SAMPLE_W-1:0] im);
        stim_t s;
        s = '{kind: STIM_SAMPLE, re: re, im: im, idx: '0, data: '0, mode: fill_mode};
        pending_in = {pending_in, s};
    endtask

    task automatic add_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        stim_t s;
        s = '{kind: STIM_WRITE, re: '0, im: '0, idx: idx, data: data, mode: fill_mode};
        pending_in = {pending_in, s};
    endtask

    task automatic add_drain();
        stim_t s;
        s = '{kind: STIM_DRAIN, re: '0, im: '0, idx: '0, data: '0, mode: fill_mode};
        pending_in = {pending_in, s};
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return ($urandom_range(1) != 0) ? 16'sh0000 : 16'shffff;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic add_random_samples(int count);
        for (int k = 0; k < count; k++)
            add_sample(pick_value(), pick_value());
    endtask

    // Short run at a fresh rate; sometimes with the run flag off or a spare-slot write.
    task automatic add_segment(int count);
        logic [CFG_W-1:0] edge_rates[9];
        logic [CFG_W-1:0] rate;
        logic [CFG_W-1:0] run_word;
        edge_rates = '{12'd0, 12'd1499, 12'd1500, 12'd2047, 12'd2048,
                       12'd2049, 12'd2500, 12'd2501, 12'd4095};
        case ($urandom_range(3))
            0:       rate = CFG_W'($urandom);
            1:       rate = edge_rates[$urandom_range(8)];
            default: rate = CFG_W'($urandom_range(RATE_MAX, RATE_MIN));
        endcase
        run_word    = CFG_W'($urandom);
        run_word[0] = ($urandom_range(7) != 0);
        add_write(lrs_pkg::REG_RUN_ENABLE, run_word);
        add_write(lrs_pkg::REG_SAMPLES_PER_MS, rate);
        add_random_samples(count / 2);
        if ($urandom_range(2) == 0)
            add_write(($urandom_range(1) != 0) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
        add_random_samples(count - count / 2);
    endtask

    initial
    begin
        fill_mode = MODE_RECV_STALLS;
        // run flag is off after reset: these are dropped
        add_sample(S_MAX, S_MIN);
        add_sample(16'shffff, 16'sh0001);
        add_write(lrs_pkg::REG_RUN_ENABLE, 12'h001);
        add_sample(S_MAX, S_MIN);
        add_sample(S_MIN, S_MAX);
        add_sample(16'sh0000, 16'sh0000);
        add_sample(16'shffff, 16'shffff);
        // below the range: clamps to the lowest rate, one or two results per sample
        add_write(lrs_pkg::REG_SAMPLES_PER_MS, 12'd0);
        add_sample(S_MAX, S_MAX);
        add_sample(S_MIN, S_MIN);
        add_sample(S_MAX, S_MIN);
        add_sample(S_MIN, S_MAX);
        add_write(REG_SPARE_A, 12'hfff);
        add_sample(16'sh1234, 16'shedcb);
        add_sample(S_MAX, 16'sh0000);
        // pass-through rate
        add_write(lrs_pkg::REG_SAMPLES_PER_MS, 12'd2048);
        add_sample(S_MIN, S_MAX);
        add_sample(S_MAX, S_MIN);
        add_sample(16'shffff, 16'sh0000);
        // above the range: clamps to the top rate, some samples yield nothing
        add_write(lrs_pkg::REG_SAMPLES_PER_MS, 12'd4095);
        add_sample(S_MAX, S_MIN);
        add_sample(S_MIN, S_MAX);
        add_sample(16'sh0001, 16'shffff);
        add_sample(S_MAX, S_MAX);
        add_write(lrs_pkg::REG_RUN_ENABLE, 12'hffe);
        add_sample(S_MIN, S_MIN);
        add_sample(S_MAX, S_MAX);

        for (int k = 0; k < 3; k++)
            add_segment($urandom_range(50, 20));
        // one long stretch at the lowest rate with no writes in between
        add_write(lrs_pkg::REG_RUN_ENABLE, 12'h001);
        add_write(lrs_pkg::REG_SAMPLES_PER_MS, CFG_W'($urandom_range(RATE_MIN, 0)));
        add_random_samples(400);
        fill_mode = MODE_SEND_GAPS;
        add_random_samples(200);
        add_drain();
        add_random_samples(200);
        fill_mode = MODE_NO_GAPS;
        add_random_samples(250);
        for (int k = 0; k < 2; k++)
            add_segment($urandom_range(50, 20));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (drained);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_out.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lrs_pkg.sv
hdl/lrs_fifo.sv
hdl/lrs_front.sv
hdl/lrs_back.sv
hdl/linear_interp_resampler_to_2048.sv
dv/tb_linear_interp_resampler_to_2048.sv
